FILE: src/ntc_pkg.sv
// shared types and constants for the ntc temperature converter
`timescale 1ns / 1ps
package ntc_pkg;

  typedef enum logic [2:0] {
    REG_FULL_SCALE = 3'd0,
    REG_LOW_SIDE   = 3'd1,
    REG_FIXED_RES  = 3'd2,
    REG_REF_TEMP   = 3'd3,
    REG_BETA       = 3'd4,
    REG_REF_RES    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RAIL    = 2'd1,
    ST_NOT_POS = 2'd2
  } status_e;

  localparam int MantBits = 32;
  localparam int FracBits = 30;
  localparam int ProdBits = 36;

  localparam logic [27:0] Ln2Q28 = 28'd186065279;
  localparam logic [39:0] HundredQ32 = 40'd429496729600;
  localparam logic [16:0] KelvinOffset = 17'd27315;
  localparam logic [39:0] TkMax = 40'd57315;
  localparam logic [15:0] TempMax = 16'd30000;
  localparam int TempMin = -27315;
  localparam int TempHigh = 30000;

endpackage

FILE: src/ntc_pdiv.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ntc_pdiv #(
  parameter int NW = 40,
  parameter int DW = 38,
  parameter int QW = 40,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          v_q   [QW];
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] w_q   [QW];
  logic [DW-1:0] d_q   [QW];
  logic [SW-1:0] s_q   [QW];
  logic [DW-1:0] rem0;

  if (NW > QW) begin : g_hi
    assign rem0 = DW'(dividend_i[NW-1:QW]);
  end else begin : g_nohi
    assign rem0 = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_p;
    logic [DW-1:0] rem_p;
    logic [DW-1:0] d_p;
    logic [QW-1:0] w_p;
    logic [SW-1:0] s_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p   = valid_i;
      assign rem_p = rem0;
      assign w_p   = dividend_i[QW-1:0];
      assign d_p   = divisor_i;
      assign s_p   = side_i;
    end else begin : g_next
      assign v_p   = v_q[k-1];
      assign rem_p = rem_q[k-1];
      assign w_p   = w_q[k-1];
      assign d_p   = d_q[k-1];
      assign s_p   = s_q[k-1];
    end

    assign trial = {rem_p, w_p[QW-1]};
    assign diff  = trial - {1'b0, d_p};
    assign ge    = trial >= {1'b0, d_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        w_q[k]   <= {w_p[QW-2:0], ge};
        d_q[k]   <= d_p;
        s_q[k]   <= s_p;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = w_q[QW-1];
  assign side_o  = s_q[QW-1];

endmodule

FILE: src/ntc_log2.sv
// pipelined log2 fraction by repeated squaring, two lanes
`timescale 1ns / 1ps
module ntc_log2 #(
  parameter int SW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [ntc_pkg::MantBits-1:0]  ma_i,
  input  logic [ntc_pkg::MantBits-1:0]  mb_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [ntc_pkg::FracBits-1:0]  frac_a_o,
  output logic [ntc_pkg::FracBits-1:0]  frac_b_o,
  output logic [SW-1:0]                 side_o
);

  localparam int MB = ntc_pkg::MantBits;
  localparam int FB = ntc_pkg::FracBits;

  logic          v_q  [FB];
  logic [MB-1:0] ma_q [FB];
  logic [MB-1:0] mb_q [FB];
  logic [FB-1:0] fa_q [FB];
  logic [FB-1:0] fb_q [FB];
  logic [SW-1:0] s_q  [FB];

  for (genvar k = 0; k < FB; k++) begin : g_stage
    logic          v_p;
    logic [MB-1:0] ma_p;
    logic [MB-1:0] mb_p;
    logic [FB-1:0] fa_p;
    logic [FB-1:0] fb_p;
    logic [SW-1:0] s_p;
    logic [2*MB-1:0] sq_a;
    logic [2*MB-1:0] sq_b;
    logic [MB:0]   ta;
    logic [MB:0]   tb;

    if (k == 0) begin : g_first
      assign v_p  = valid_i;
      assign ma_p = ma_i;
      assign mb_p = mb_i;
      assign fa_p = '0;
      assign fb_p = '0;
      assign s_p  = side_i;
    end else begin : g_next
      assign v_p  = v_q[k-1];
      assign ma_p = ma_q[k-1];
      assign mb_p = mb_q[k-1];
      assign fa_p = fa_q[k-1];
      assign fb_p = fb_q[k-1];
      assign s_p  = s_q[k-1];
    end

    assign sq_a = ma_p * ma_p;
    assign sq_b = mb_p * mb_p;
    assign ta   = sq_a[2*MB-1:MB-1];
    assign tb   = sq_b[2*MB-1:MB-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ma_q[k] <= ta[MB] ? ta[MB:1] : ta[MB-1:0];
        mb_q[k] <= tb[MB] ? tb[MB:1] : tb[MB-1:0];
        fa_q[k] <= {fa_p[FB-2:0], ta[MB]};
        fb_q[k] <= {fb_p[FB-2:0], tb[MB]};
        s_q[k]  <= s_p;
      end
    end
  end

  assign valid_o  = v_q[FB-1];
  assign frac_a_o = fa_q[FB-1];
  assign frac_b_o = fb_q[FB-1];
  assign side_o   = s_q[FB-1];

endmodule

FILE: src/ntc_adc_to_temperature.sv
// top level of the ntc adc sample to temperature converter
//
//  channel | signals                                  | direction
//  cfg     | cfg_we_i cfg_index_i cfg_data_i          | in, write only
//  in      | in_valid_i in_stall_o sample_i           | in
//  out     | out_valid_o out_stall_i temp_centi_c_o status_o | out
//
// one sample per cycle unless out_stall_i holds a waiting result
// latency is set mostly by the 30 log2 squaring stages and the two bit-serial
// divider pipelines (38 and 40 stages)
// such a stall holds all but the 1/t0 divider, nothing is lost
// reset clears all valid bits and loads register defaults
`timescale 1ns / 1ps
module ntc_adc_to_temperature #(
  parameter int ADC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] temp_centi_c_o,
  output logic [1:0]         status_o
);

  localparam int PB = ntc_pkg::ProdBits;
  localparam int FB = ntc_pkg::FracBits;
  localparam int MB = ntc_pkg::MantBits;
  localparam logic [15:0] AdcMask =
    (ADC_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADC_BITS) - 32'd1);

  function automatic logic [5:0] lead_one(input logic [PB-1:0] x);
    logic [5:0] l;
    l = '0;
    for (int i = 0; i < PB; i++) begin
      if (x[i]) l = 6'(i);
    end
    return l;
  endfunction

  // configuration registers
  logic [15:0] fsc_q;
  logic        low_q;
  logic [19:0] rf_q;
  logic [14:0] t0_q;
  logic [13:0] beta_q;
  logic [19:0] r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsc_q  <= 16'd4095;
      low_q  <= 1'b0;
      rf_q   <= 20'd10000;
      t0_q   <= 15'd2500;
      beta_q <= 14'd3950;
      r0_q   <= 20'd10000;
    end else if (cfg_we_i) begin
      case (ntc_pkg::cfg_reg_e'(cfg_index_i))
        ntc_pkg::REG_FULL_SCALE: fsc_q  <= cfg_data_i[15:0];
        ntc_pkg::REG_LOW_SIDE:   low_q  <= cfg_data_i[0];
        ntc_pkg::REG_FIXED_RES:  rf_q   <= cfg_data_i;
        ntc_pkg::REG_REF_TEMP:   t0_q   <= cfg_data_i[14:0];
        ntc_pkg::REG_BETA:       beta_q <= cfg_data_i[13:0];
        ntc_pkg::REG_REF_RES:    r0_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  logic [19:0] r0_eff;
  logic [13:0] beta_eff;
  assign r0_eff   = (r0_q == '0) ? 20'd1 : r0_q;
  assign beta_eff = (beta_q == '0) ? 14'd1 : beta_q;

  // stage a: clamp, rail check, divider ratio
  logic [15:0] s_m, f_m, s_c;
  logic        rail_a_d;
  assign s_m      = sample_i & AdcMask;
  assign f_m      = fsc_q & AdcMask;
  assign s_c      = (s_m > f_m) ? f_m : s_m;
  assign rail_a_d = (f_m == '0) || (s_c == '0) || (s_c >= f_m) || (rf_q == '0);

  logic        va_q, rail_a_q;
  logic [15:0] num_a_q, den_a_q;

  // stage b: products
  logic [PB-1:0] a_b_d, b_b_d;
  logic [PB-1:0] a_b_q, b_b_q;
  logic          vb_q, rail_b_q;
  assign a_b_d = rf_q * num_a_q;
  assign b_b_d = den_a_q * r0_eff;

  // stage c: leading one
  logic [PB-1:0] a_c_q, b_c_q;
  logic [5:0]    la_c_q, lb_c_q;
  logic          vc_q, rail_c_q;

  // stage d: normalize to q31 mantissa
  logic [MB-1:0] ma_d_d, mb_d_d, ma_d_q, mb_d_q;
  logic [5:0]    la_d_q, lb_d_q;
  logic          vd_q, rail_d_q;

  always_comb begin
    if (la_c_q > 6'd31) ma_d_d = MB'(a_c_q >> (la_c_q - 6'd31));
    else                ma_d_d = MB'(a_c_q << (6'd31 - la_c_q));
    if (lb_c_q > 6'd31) mb_d_d = MB'(b_c_q >> (lb_c_q - 6'd31));
    else                mb_d_d = MB'(b_c_q << (6'd31 - lb_c_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rail_a_q <= rail_a_d;
      num_a_q  <= low_q ? s_c : f_m - s_c;
      den_a_q  <= low_q ? f_m - s_c : s_c;
      a_b_q    <= a_b_d;
      b_b_q    <= b_b_d;
      rail_b_q <= rail_a_q;
      a_c_q    <= a_b_q;
      b_c_q    <= b_b_q;
      la_c_q   <= lead_one(a_b_q);
      lb_c_q   <= lead_one(b_b_q);
      rail_c_q <= rail_b_q;
      ma_d_q   <= ma_d_d;
      mb_d_q   <= mb_d_d;
      la_d_q   <= la_c_q;
      lb_d_q   <= lb_c_q;
      rail_d_q <= rail_c_q;
    end
  end

  // log2 fractions
  logic          vl;
  logic [FB-1:0] fa_l, fb_l;
  logic [12:0]   side_l;

  ntc_log2 #(.SW(13)) u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vd_q),
    .ma_i     (ma_d_q),
    .mb_i     (mb_d_q),
    .side_i   ({rail_d_q, la_d_q, lb_d_q}),
    .valid_o  (vl),
    .frac_a_o (fa_l),
    .frac_b_o (fb_l),
    .side_o   (side_l)
  );

  // stage e: log difference
  logic [PB-1:0] la_e, lb_e;
  logic [PB-1:0] mag_e_q;
  logic          neg_e_q, rail_e_q, ve_q;
  assign la_e = {side_l[11:6], fa_l};
  assign lb_e = {side_l[5:0], fb_l};

  // stage f: times ln2 in two halves
  logic [45:0] plo_f_q, phi_f_q;
  logic        neg_f_q, rail_f_q, vf_q;

  // stage g: sum and drop 26 bits
  logic [63:0] p_g;
  logic [37:0] n_g_q;
  logic        neg_g_q, rail_g_q, vg_q;
  assign p_g = {phi_f_q, 18'b0} + 64'(plo_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en) begin
      ve_q <= vl;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_e_q  <= lb_e > la_e;
      mag_e_q  <= (lb_e > la_e) ? lb_e - la_e : la_e - lb_e;
      rail_e_q <= side_l[12];
      plo_f_q  <= mag_e_q[17:0] * ntc_pkg::Ln2Q28;
      phi_f_q  <= mag_e_q[35:18] * ntc_pkg::Ln2Q28;
      neg_f_q  <= neg_e_q;
      rail_f_q <= rail_e_q;
      n_g_q    <= p_g[63:26];
      neg_g_q  <= neg_f_q;
      rail_g_q <= rail_f_q;
    end
  end

  // ln term over beta
  logic        vt;
  logic [37:0] term_t;
  logic [1:0]  side_t;

  ntc_pdiv #(.NW(38), .DW(14), .QW(38), .SW(2)) u_div_term (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vg_q),
    .dividend_i (n_g_q),
    .divisor_i  (beta_eff),
    .side_i     ({neg_g_q, rail_g_q}),
    .valid_o    (vt),
    .quot_o     (term_t),
    .side_o     (side_t)
  );

  // 1/t0 from registers only, free running
  logic signed [16:0] t0k_s;
  logic [15:0]        t0k;
  logic [38:0]        inv0_n;
  logic [25:0]        inv0;
  assign t0k_s  = 17'(signed'(t0_q)) + signed'(ntc_pkg::KelvinOffset);
  assign t0k    = t0k_s[15:0];
  assign inv0_n = 39'(ntc_pkg::HundredQ32) + 39'(t0k[15:1]);

  ntc_pdiv #(.NW(39), .DW(16), .QW(26), .SW(1)) u_div_inv0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (1'b1),
    .valid_i    (1'b1),
    .dividend_i (inv0_n),
    .divisor_i  (t0k),
    .side_i     (1'b0),
    .valid_o    (),
    .quot_o     (inv0),
    .side_o     ()
  );

  // stage h: inverse temperature
  logic signed [39:0] inv_h_d, inv_h_q;
  logic               rail_h_q, vh_q;
  assign inv_h_d = side_t[1] ? signed'({14'b0, inv0}) - signed'({2'b0, term_t})
                             : signed'({14'b0, inv0}) + signed'({2'b0, term_t});

  // stage i: rounding dividend
  logic [37:0] q_i;
  logic [37:0] q_i_q;
  logic [39:0] n_i_q;
  logic [1:0]  st_i_q;
  logic        vi_q;
  assign q_i = inv_h_q[37:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vi_q <= 1'b0;
    end else if (en) begin
      vh_q <= vt;
      vi_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_h_q  <= inv_h_d;
      rail_h_q <= side_t[0];
      q_i_q    <= q_i;
      n_i_q    <= ntc_pkg::HundredQ32 + 40'(q_i[37:1]);
      if (rail_h_q)           st_i_q <= ntc_pkg::ST_RAIL;
      else if (inv_h_q <= 0)  st_i_q <= ntc_pkg::ST_NOT_POS;
      else                    st_i_q <= ntc_pkg::ST_OK;
    end
  end

  // temperature in centi kelvin
  logic        vk;
  logic [39:0] tk;
  logic [1:0]  st_k;

  ntc_pdiv #(.NW(40), .DW(38), .QW(40), .SW(2)) u_div_tk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vi_q),
    .dividend_i (n_i_q),
    .divisor_i  (q_i_q),
    .side_i     (st_i_q),
    .valid_o    (vk),
    .quot_o     (tk),
    .side_o     (st_k)
  );

  // output register
  logic signed [16:0] tc;
  logic [15:0]        temp_d, temp_q;
  logic [1:0]         status_q;
  assign tc = signed'({1'b0, tk[15:0]}) - signed'(ntc_pkg::KelvinOffset);

  always_comb begin
    if (st_k != ntc_pkg::ST_OK) temp_d = '0;
    else if (tk > ntc_pkg::TkMax) temp_d = ntc_pkg::TempMax;
    else temp_d = tc[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q   <= temp_d;
      status_q <= st_k;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign temp_centi_c_o = signed'(temp_q);
  assign status_o       = status_q;

endmodule

FILE: src/ntc_chk.sv
// port checker for the ntc temperature converter and its bind
`timescale 1ns / 1ps
module ntc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] temp_centi_c_o,
  input logic [1:0]         status_o
);

  // upstream is held only by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // error results carry zero temperature
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ntc_pkg::ST_RAIL || status_o == ntc_pkg::ST_NOT_POS)
    |-> temp_centi_c_o == 16'sd0)
    else $error("nonzero temperature on error status");

  // valid results stay in the saturated range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ntc_pkg::ST_OK
    |-> int'(temp_centi_c_o) >= ntc_pkg::TempMin && int'(temp_centi_c_o) <= ntc_pkg::TempHigh)
    else $error("temperature out of range");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ntc_pkg::ST_OK || status_o == ntc_pkg::ST_RAIL
                    || status_o == ntc_pkg::ST_NOT_POS)
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temp_centi_c_o)
                                   && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind ntc_adc_to_temperature ntc_chk u_ntc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .temp_centi_c_o (temp_centi_c_o),
  .status_o       (status_o)
);
